### hdl/assert_macros.svh
// assertion macros used by ptp_system_time_counter_core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hdl/ptp_stc_pkg.sv
// types and constants for the ptp system time counter
// no dependencies
`timescale 1ns / 1ps

package ptp_stc_pkg;

   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_START  = 3'd1;
   localparam logic [2:0] MODE_STOP   = 3'd2;
   localparam logic [2:0] MODE_INIT   = 3'd3;
   localparam logic [2:0] MODE_ADD    = 3'd4;
   localparam logic [2:0] MODE_CLEAR  = 3'd5;
   localparam logic [2:0] MODE_STATUS = 3'd6;

   localparam logic [2:0] CSR_SUBSEC_INC  = 3'd0;
   localparam logic [2:0] CSR_FINE_ADDEND = 3'd1;
   localparam logic [2:0] CSR_FINE_ENABLE = 3'd2;
   localparam logic [2:0] CSR_DEC_ROLL    = 3'd3;
   localparam logic [2:0] CSR_TARGET_SEC  = 3'd4;
   localparam logic [2:0] CSR_TARGET_SUB  = 3'd5;
   localparam logic [2:0] CSR_IRQ_ENABLE  = 3'd6;

   localparam int CsrDataWidth = 32;

   localparam logic [32:0] LIMIT_DECIMAL = 33'h0_3b9a_c9ff;
   localparam logic [32:0] LIMIT_BINARY  = 33'h0_7fff_ffff;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] update_seconds;
      logic [31:0] update_subseconds;
   } req_type;

   typedef struct packed {
      logic [31:0] seconds_now;
      logic [31:0] subseconds_now;
      logic        target_reached;
      logic        target_error;
      logic        interrupt_level;
      logic        is_running;
   } rsp_type;

endpackage

### hdl/ptp_system_time_counter_core.sv
// ptp system time counter with fine-correction accumulator and target time
// depends on ptp_stc_pkg and assert_macros.svh
`timescale 1ns / 1ps
//
// usage
// - req channel (valid/ready) carries one command transaction: tick, start,
//   stop, init, add update, clear target or read status, plus update values
// - rsp channel (valid/ready) returns one transaction per command with the
//   time and status flags as they stand after that command
// - csr port writes the configuration registers by index, one per cycle;
//   the user must make writes only while no command is in flight (not enforced)
// - path: an accepted req goes into the input register, then one pass of update
//   logic writes the result register, which drives rsp valid
// - throughput: one transaction per cycle while rsp_ready is high; the state
//   update is a single pass of accumulator add, 33-bit sub-second add and a
//   64-bit target compare between the input register and the result register
// - when rsp_ready is low the result register holds its transaction and the
//   input register holds one more; req_ready falls only when both are full
// - reset clears time, flags, accumulator and all configuration registers;
//   the counter comes up stopped
//
`include "assert_macros.svh"

module ptp_system_time_counter_core
   import ptp_stc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   // configuration
   logic [30:0] inc_ff;
   logic [31:0] addend_ff;
   logic        fine_en_ff;
   logic        dec_roll_ff;
   logic [31:0] tgt_sec_ff;
   logic [31:0] tgt_sub_ff;
   logic        irq_en_ff;

   // time state
   logic [31:0] sec_ff, sec_in;
   logic [31:0] sub_ff, sub_in;
   logic [31:0] acc_ff, acc_in;
   logic        reached_ff, reached_in;
   logic        error_ff, error_in;
   logic        irq_ff, irq_in;
   logic        run_ff, run_in;

   // pipeline
   logic    s1_valid_ff;
   req_type s1_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    out_free;
   logic    fire;

   // datapath
   logic [32:0] acc_sum;
   logic [32:0] sub_sum;
   logic [32:0] limit;
   logic        wrap;
   logic        advance;
   logic [31:0] adv_sec;
   logic [31:0] adv_sub;
   logic        past_now;
   logic        past_adv;
   logic        error_shown;

   function automatic logic at_or_past(input logic [31:0] sec, input logic [31:0] sub,
                                       input logic [31:0] tsec, input logic [31:0] tsub);
      if (sec != tsec) begin
         return sec > tsec;
      end
      return sub >= tsub;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign acc_sum  = {1'b0, acc_ff} + {1'b0, addend_ff};
   assign sub_sum  = {1'b0, sub_ff} + {2'b00, inc_ff};
   assign limit    = dec_roll_ff ? LIMIT_DECIMAL : LIMIT_BINARY;
   assign wrap     = sub_sum > limit;
   assign adv_sec  = wrap ? sec_ff + 32'd1 : sec_ff;
   assign adv_sub  = wrap ? 32'd0 : sub_sum[31:0];
   assign advance  = run_ff && (!fine_en_ff || acc_sum[32]);
   assign past_now = at_or_past(sec_ff, sub_ff, tgt_sec_ff, tgt_sub_ff);
   assign past_adv = at_or_past(adv_sec, adv_sub, tgt_sec_ff, tgt_sub_ff);

   always_comb begin
      sec_in     = sec_ff;
      sub_in     = sub_ff;
      acc_in     = acc_ff;
      reached_in = reached_ff;
      error_in   = error_ff;
      irq_in     = irq_ff;
      run_in     = run_ff;
      case (s1_ff.mode)
         MODE_TICK: begin
            if (run_ff && fine_en_ff) begin
               acc_in = acc_sum[31:0];
            end
            if (advance) begin
               sec_in = adv_sec;
               sub_in = adv_sub;
               if (past_adv && !reached_ff) begin
                  reached_in = 1'b1;
                  if (irq_en_ff) begin
                     irq_in = 1'b1;
                  end
               end
            end
         end
         MODE_START: begin
            acc_in = '0;
            if (past_now) begin
               error_in = 1'b1;
            end else begin
               run_in = 1'b1;
            end
         end
         MODE_STOP: begin
            run_in = 1'b0;
         end
         MODE_INIT: begin
            sec_in = s1_ff.update_seconds;
            sub_in = s1_ff.update_subseconds;
         end
         MODE_ADD: begin
            sec_in = sec_ff + s1_ff.update_seconds;
            sub_in = sub_ff + s1_ff.update_subseconds;
         end
         MODE_CLEAR: begin
            reached_in = 1'b0;
            irq_in     = 1'b0;
         end
         default: begin
         end
      endcase
      error_shown = error_in;
      if (s1_ff.mode == MODE_STATUS) begin
         error_in = 1'b0;
      end
      rsp_in.seconds_now     = sec_in;
      rsp_in.subseconds_now  = sub_in;
      rsp_in.target_reached  = reached_in;
      rsp_in.target_error    = error_shown;
      rsp_in.interrupt_level = irq_in;
      rsp_in.is_running      = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff       <= '0;
         addend_ff    <= '0;
         fine_en_ff   <= 1'b0;
         dec_roll_ff  <= 1'b0;
         tgt_sec_ff   <= '0;
         tgt_sub_ff   <= '0;
         irq_en_ff    <= 1'b0;
         sec_ff       <= '0;
         sub_ff       <= '0;
         acc_ff       <= '0;
         reached_ff   <= 1'b0;
         error_ff     <= 1'b0;
         irq_ff       <= 1'b0;
         run_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SUBSEC_INC:  inc_ff      <= csr_wdata[30:0];
               CSR_FINE_ADDEND: addend_ff   <= csr_wdata[31:0];
               CSR_FINE_ENABLE: fine_en_ff  <= csr_wdata[0];
               CSR_DEC_ROLL:    dec_roll_ff <= csr_wdata[0];
               CSR_TARGET_SEC:  tgt_sec_ff  <= csr_wdata[31:0];
               CSR_TARGET_SUB:  tgt_sub_ff  <= csr_wdata[31:0];
               CSR_IRQ_ENABLE:  irq_en_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (fire) begin
            sec_ff     <= sec_in;
            sub_ff     <= sub_in;
            acc_ff     <= acc_in;
            reached_ff <= reached_in;
            error_ff   <= error_in;
            irq_ff     <= irq_in;
            run_ff     <= run_in;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // interrupt is only raised together with the reached flag
   `ASSERT_IMPLIES(a_irq_needs_reached, clock, reset, irq_ff, reached_ff)
   // a tick while stopped leaves the time alone
   `ASSERT_NEXT(a_stopped_tick_holds, clock, reset, fire && s1_ff.mode == MODE_TICK && !run_ff, $stable(sec_ff) && $stable(sub_ff))
   // a processed command always lands in the result register
   `ASSERT_NEXT(a_fire_gives_rsp, clock, reset, fire, rsp_valid_ff)
   // status read clears the error flag
   `ASSERT_NEXT(a_status_clears_error, clock, reset, fire && s1_ff.mode == MODE_STATUS, !error_ff)

endmodule

### test/time_counter_checker.sv
// checker for the ptp system time counter: follows csr writes, predicts each rsp
// transaction from the accepted req transactions and compares field by field
// depends on ptp_stc_pkg
`timescale 1ns / 1ps

module time_counter_checker
   import ptp_stc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  req_type                 req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output int                      fail_count,
   output int                      pending
);

   logic [30:0] subsec_inc;
   logic [31:0] addend;
   logic        fine_mode;
   logic        decimal_mode;
   logic [31:0] target_sec;
   logic [31:0] target_sub;
   logic        irq_enable;

   logic [31:0] sec_count;
   logic [31:0] sub_count;
   logic [31:0] accum;
   logic        reached;
   logic        error;
   logic        irq;
   logic        running;

   rsp_type expected_times[$];

   function automatic logic past_target();
      return {sec_count, sub_count} >= {target_sec, target_sub};
   endfunction

   task automatic advance_time();
      logic [32:0] sum;
      sum = {1'b0, sub_count} + {2'b00, subsec_inc};
      if (sum > (decimal_mode ? LIMIT_DECIMAL : LIMIT_BINARY)) begin
         sub_count = '0;
         sec_count = sec_count + 32'd1;
      end else begin
         sub_count = sum[31:0];
      end
      if (past_target() && !reached) begin
         reached = 1'b1;
         if (irq_enable) irq = 1'b1;
      end
   endtask

   task automatic predict_time(input req_type cmd);
      logic [32:0] acc_sum;
      rsp_type     want;
      case (cmd.mode)
         MODE_TICK: begin
            if (running) begin
               if (!fine_mode) begin
                  advance_time();
               end else begin
                  acc_sum = {1'b0, accum} + {1'b0, addend};
                  accum = acc_sum[31:0];
                  if (acc_sum[32]) advance_time();
               end
            end
         end
         MODE_START: begin
            accum = '0;
            if (past_target()) error = 1'b1;
            else running = 1'b1;
         end
         MODE_STOP: running = 1'b0;
         MODE_INIT: begin
            sec_count = cmd.update_seconds;
            sub_count = cmd.update_subseconds;
         end
         MODE_ADD: begin
            sec_count = sec_count + cmd.update_seconds;
            sub_count = sub_count + cmd.update_subseconds;
         end
         MODE_CLEAR: begin
            reached = 1'b0;
            irq = 1'b0;
         end
         default: ;
      endcase
      want.seconds_now     = sec_count;
      want.subseconds_now  = sub_count;
      want.target_reached  = reached;
      want.target_error    = error;
      want.interrupt_level = irq;
      want.is_running      = running;
      if (cmd.mode == MODE_STATUS) error = 1'b0;
      expected_times.push_back(want);
   endtask

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         subsec_inc   = '0;
         addend       = '0;
         fine_mode    = 1'b0;
         decimal_mode = 1'b0;
         target_sec   = '0;
         target_sub   = '0;
         irq_enable   = 1'b0;
         sec_count    = '0;
         sub_count    = '0;
         accum        = '0;
         reached      = 1'b0;
         error        = 1'b0;
         irq          = 1'b0;
         running      = 1'b0;
         expected_times.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SUBSEC_INC:  subsec_inc   = csr_wdata[30:0];
               CSR_FINE_ADDEND: addend       = csr_wdata;
               CSR_FINE_ENABLE: fine_mode    = csr_wdata[0];
               CSR_DEC_ROLL:    decimal_mode = csr_wdata[0];
               CSR_TARGET_SEC:  target_sec   = csr_wdata;
               CSR_TARGET_SUB:  target_sub   = csr_wdata;
               CSR_IRQ_ENABLE:  irq_enable   = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_times.size() == 0) begin
               report("unexpected rsp transaction (seconds)", '0, rsp_data.seconds_now);
            end else begin
               want = expected_times.pop_front();
               if (rsp_data.seconds_now !== want.seconds_now)
                  report("seconds_now", want.seconds_now, rsp_data.seconds_now);
               if (rsp_data.subseconds_now !== want.subseconds_now)
                  report("subseconds_now", want.subseconds_now, rsp_data.subseconds_now);
               if (rsp_data.target_reached !== want.target_reached)
                  report("target_reached", 32'(want.target_reached),
                         32'(rsp_data.target_reached));
               if (rsp_data.target_error !== want.target_error)
                  report("target_error", 32'(want.target_error),
                         32'(rsp_data.target_error));
               if (rsp_data.interrupt_level !== want.interrupt_level)
                  report("interrupt_level", 32'(want.interrupt_level),
                         32'(rsp_data.interrupt_level));
               if (rsp_data.is_running !== want.is_running)
                  report("is_running", 32'(want.is_running), 32'(rsp_data.is_running));
            end
         end
         if (req_valid && req_ready) predict_time(req_data);
      end
      pending <= expected_times.size();
   end

endmodule

### test/tb.sv
// testbench top for ptp_system_time_counter_core: clock, reset, csr setup,
// directed and random command transactions, watchdog and verdict
// depends on ptp_stc_pkg, ptp_system_time_counter_core and time_counter_checker
`timescale 1ns / 1ps

module tb;
   import ptp_stc_pkg::*;

   localparam logic [2:0] MODE_UNUSED = 3'd7;
   localparam int ItemTarget    = 1950;
   localparam int WatchdogLimit = 2000;
   localparam int IdlePercent   = 7;
   localparam int SettleCycles  = 4;
   localparam int QuietPhase    = 3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we = 1'b0;
   logic [2:0]              csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   int   fail_count;
   int   pending;
   int   items_sent = 0;
   int   dead_cycles = 0;
   logic no_idle = 1'b0;

   always #5 clock = ~clock;

   ptp_system_time_counter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   time_counter_checker time_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= IdlePercent);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         dead_cycles <= 0;
      else
         dead_cycles <= dead_cycles + 1;
      if (dead_cycles >= WatchdogLimit) begin
         $display("** ptp_system_time_counter_core: FAILED **");
         $finish;
      end
   end

   task automatic send_cmd(input logic [2:0] mode, input logic [31:0] sec,
                           input logic [31:0] sub);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < IdlePercent) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= {mode, sec, sub};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [31:0] inc, input logic [31:0] addend,
                              input logic fine, input logic decimal,
                              input logic [31:0] tsec, input logic [31:0] tsub,
                              input logic irq_en);
      write_csr(CSR_SUBSEC_INC, inc);
      write_csr(CSR_FINE_ADDEND, addend);
      write_csr(CSR_FINE_ENABLE, {31'd0, fine});
      write_csr(CSR_DEC_ROLL, {31'd0, decimal});
      write_csr(CSR_TARGET_SEC, tsec);
      write_csr(CSR_TARGET_SUB, tsub);
      write_csr(CSR_IRQ_ENABLE, {31'd0, irq_en});
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] base_sec;
      logic [31:0] inc;
      logic [31:0] addend;
      logic [31:0] tsub;
      logic [31:0] usec;
      logic [31:0] usub;
      logic [2:0]  mode;
      int          pick;
      int          phase_len;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // coarse mode, binary rollover: one second per two ticks, target at 2 s
      load_config(32'h7fffffff, '0, 1'b0, 1'b0, 32'd2, '0, 1'b1);
      send_cmd(MODE_TICK, '0, '0);
      send_cmd(MODE_STATUS, '0, '0);
      send_cmd(MODE_START, '0, '0);
      repeat (4) send_cmd(MODE_TICK, '1, '1);
      send_cmd(MODE_CLEAR, '0, '0);
      send_cmd(MODE_START, '0, '0);
      send_cmd(MODE_STATUS, '0, '0);
      send_cmd(MODE_STATUS, '0, '0);
      send_cmd(MODE_INIT, 32'hffffffff, 32'hffffffff);
      send_cmd(MODE_TICK, '0, '0);
      send_cmd(MODE_ADD, 32'hffffffff, 32'hffffffff);
      send_cmd(MODE_ADD, '0, '0);
      send_cmd(MODE_UNUSED, 32'hffffffff, 32'hffffffff);
      send_cmd(MODE_STOP, '0, '0);
      send_cmd(MODE_TICK, '0, '0);
      send_cmd(MODE_INIT, '0, '0);
      wait_for_results();

      // fine mode with full addend, decimal rollover, zero increment
      load_config('0, 32'hffffffff, 1'b1, 1'b1, 32'hffffffff, 32'hffffffff, 1'b0);
      send_cmd(MODE_START, '0, '0);
      send_cmd(MODE_TICK, '0, '0);
      send_cmd(MODE_TICK, '0, '0);
      send_cmd(MODE_INIT, '0, 32'h3b9aca00);
      send_cmd(MODE_TICK, '0, '0);
      send_cmd(MODE_STATUS, '0, '0);
      wait_for_results();

      for (int phase = 0; items_sent < ItemTarget; phase++) begin
         no_idle <= (phase == QuietPhase);
         case ($urandom_range(0, 2))
            0:       base_sec = $urandom;
            1:       base_sec = 32'hfffffffe;
            default: base_sec = $urandom_range(0, 10);
         endcase
         case ($urandom_range(0, 4))
            0:       inc = '0;
            1:       inc = 32'h7fffffff;
            2:       inc = $urandom_range(1, 1000);
            3:       inc = 32'h1dcd6500;
            default: inc = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       addend = '0;
            1:       addend = 32'hffffffff;
            2:       addend = 32'h80000000;
            default: addend = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       tsub = '0;
            1:       tsub = 32'hffffffff;
            2:       tsub = $urandom_range(0, 32'h3b9ac9ff);
            default: tsub = $urandom;
         endcase
         load_config(inc, addend, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     base_sec + $urandom_range(0, 3), tsub, 1'($urandom_range(0, 1)));
         send_cmd(MODE_INIT, base_sec, $urandom_range(0, 1000));
         send_cmd(MODE_CLEAR, $urandom, $urandom);
         send_cmd(MODE_START, $urandom, $urandom);
         phase_len = $urandom_range(80, 220);
         if (phase_len > ItemTarget - items_sent) phase_len = ItemTarget - items_sent;
         if (phase_len < 0) phase_len = 0;
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            usec = $urandom;
            usub = $urandom;
            if (pick < 62) begin
               mode = MODE_TICK;
            end else if (pick < 67) begin
               mode = MODE_START;
            end else if (pick < 71) begin
               mode = MODE_STOP;
            end else if (pick < 75) begin
               mode = MODE_INIT;
               if (pick < 74) begin
                  usec = base_sec + $urandom_range(0, 3);
                  usub = $urandom_range(0, 32'h3b9ac9ff);
               end
            end else if (pick < 80) begin
               mode = MODE_ADD;
               if (pick < 79) begin
                  usec = $urandom_range(0, 1);
                  usub = $urandom_range(0, 1000);
               end
            end else if (pick < 86) begin
               mode = MODE_CLEAR;
            end else if (pick < 97) begin
               mode = MODE_STATUS;
            end else begin
               mode = MODE_UNUSED;
            end
            send_cmd(mode, usec, usub);
         end
         wait_for_results();
      end

      if (fail_count == 0)
         $display("** ptp_system_time_counter_core: PASSED **");
      else
         $display("** ptp_system_time_counter_core: FAILED **");
      $finish;
   end

endmodule
